### src/pes_pkg.sv
// shared types and constants for the polygon edge setup block
package pes_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_POINT  = 2'd0,
        OP_LOAD_VERTEX = 2'd1,
        OP_FIND_TOP    = 2'd2,
        OP_SETUP_EDGE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_VERTEX_COUNT   = 2'd0,
        CFG_TEXTURE_WIDTH  = 2'd1,
        CFG_TEXTURE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_TOP_CMP,
        ST_E_RD_FROM,
        ST_E_WAIT_FROM,
        ST_E_RD_TO,
        ST_E_WAIT_TO,
        ST_E_LATCH_TO,
        ST_E_MUL,
        ST_E_DIFF,
        ST_DIV_X_START,
        ST_DIV_X_RUN,
        ST_DIV_U_START,
        ST_DIV_U_RUN,
        ST_DIV_V_START,
        ST_DIV_V_RUN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DSEL_X = 2'd0,
        DSEL_U = 2'd1,
        DSEL_V = 2'd2
    } div_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     load_point;
        logic     load_vertex;
        logic     top_init;
        logic     top_read;
        logic     top_cmp;
        logic     top_step;
        logic     rd_from;
        logic     latch_from;
        logic     rd_to;
        logic     latch_to;
        logic     do_mul;
        logic     do_diff;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_store;
        logic     out_top;
        logic     out_edge;
    } pes_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic top_last;
        logic div_busy;
        logic rows_pos;
        logic textured;
    } pes_status_t;

endpackage

### src/pes_ram.sv
// generic single-port-write ram with registered read
module pes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/pes_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module pes_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [33:0] dividend,
    input  logic signed [16:0] divisor,
    output logic               busy,
    output logic [31:0]        quotient
);
    localparam int NW = 34;

    logic [NW-1:0]  quo_reg, quo_next;
    logic [NW:0]    rem_reg, rem_next;
    logic [16:0]    den_reg, den_next;
    logic           neg_reg, neg_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [NW:0]    trial;
    logic [NW-1:0]  mag;
    logic [NW-1:0]  signed_q;

    // one restoring step per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        mag       = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
        if (start)
        begin
            quo_next  = mag;
            rem_next  = '0;
            den_next  = divisor[16] ? 17'(-divisor) : 17'(divisor);
            neg_next  = dividend[NW-1] ^ divisor[16];
            cnt_next  = 6'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[NW-1:0], quo_reg[NW-1]} - {{(NW-16){1'b0}}, den_reg};
            if (!trial[NW])
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[NW-1:0], quo_reg[NW-1]};
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // divider state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign signed_q = neg_reg ? NW'(-quo_reg) : quo_reg;
    assign quotient = signed_q[31:0];
    assign busy     = busy_reg;
endmodule

### src/pes_datapath.sv
// datapath: point and vertex stores, edge slot state, multipliers, divider
module pes_datapath #(
    parameter int MAX_VERTICES  = 16,
    parameter int POINT_ENTRIES = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pes_pkg::pes_cmd_t    cmd,
    output pes_pkg::pes_status_t status,
    input  logic [4:0]           vertex_count,
    input  logic [12:0]          texture_width,
    input  logic [12:0]          texture_height,
    input  logic [5:0]           point_slot,
    input  logic [3:0]           position,
    input  logic signed [31:0]   coord_x,
    input  logic signed [31:0]   coord_y,
    input  logic signed [31:0]   tex_u,
    input  logic signed [31:0]   tex_v,
    input  logic signed [1:0]    direction,
    input  logic                 edge_sel,
    input  logic                 textured,
    output logic [3:0]           top_position,
    output logic [3:0]           edge_to,
    output logic signed [15:0]   edge_top,
    output logic signed [15:0]   edge_bottom,
    output logic signed [31:0]   start_x,
    output logic signed [31:0]   step_x,
    output logic signed [31:0]   start_u,
    output logic signed [31:0]   start_v,
    output logic signed [31:0]   step_u,
    output logic signed [31:0]   step_v
);
    import pes_pkg::*;

    localparam int PW = (POINT_ENTRIES > 1) ? $clog2(POINT_ENTRIES) : 1;
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // captured request
    logic [5:0]         slot_reg;
    logic [3:0]         pos_reg;
    logic signed [31:0] cx_reg, cy_reg, tu_reg, tv_reg;
    logic signed [1:0]  dir_reg;
    logic               sel_reg;
    logic               tex_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg <= point_slot;
            pos_reg  <= position;
            cx_reg   <= coord_x;
            cy_reg   <= coord_y;
            tu_reg   <= tex_u;
            tv_reg   <= tex_v;
            dir_reg  <= direction;
            sel_reg  <= edge_sel;
            tex_reg  <= textured;
        end
    end

    // effective vertex count, clamped to 1..MAX_VERTICES
    logic [CW-1:0] count_eff;
    always_comb
    begin
        if (vertex_count == 5'd0)
            count_eff = CW'(1);
        else if (32'(vertex_count) > MAX_VERTICES)
            count_eff = CW'(MAX_VERTICES);
        else
            count_eff = CW'(vertex_count);
    end

    // wrapped target position
    logic signed [7:0] to_raw;
    logic [3:0]        to_pos;
    always_comb
    begin
        to_raw = 8'(signed'({4'd0, pos_reg})) + 8'(dir_reg);
        if (to_raw < 0)
            to_pos = 4'(count_eff - CW'(1));
        else if (to_raw >= 8'(count_eff))
            to_pos = 4'd0;
        else
            to_pos = to_raw[3:0];
    end

    // vertex memories
    logic [VW-1:0] vaddr;
    logic [CW-1:0] scan_reg, scan_next;
    logic [VW-1:0] best_reg;
    logic [5:0]    vslot_rd;
    logic [31:0]   vu_rd, vv_rd;

    always_comb
    begin
        if (cmd.load_vertex || cmd.rd_from)
            vaddr = VW'(pos_reg);
        else if (cmd.rd_to)
            vaddr = VW'(to_pos);
        else
            vaddr = VW'(scan_reg);
    end

    pes_ram #(.WIDTH(6), .DEPTH(MAX_VERTICES)) u_vslot (
        .clk(clk), .we(cmd.load_vertex), .waddr(VW'(pos_reg)), .wdata(slot_reg),
        .raddr(vaddr), .rdata(vslot_rd));
    pes_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vu (
        .clk(clk), .we(cmd.load_vertex), .waddr(VW'(pos_reg)), .wdata(tu_reg),
        .raddr(vaddr), .rdata(vu_rd));
    pes_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vv (
        .clk(clk), .we(cmd.load_vertex), .waddr(VW'(pos_reg)), .wdata(tv_reg),
        .raddr(vaddr), .rdata(vv_rd));

    // point memories, addressed by the captured slot on a point load, else by the slot just read from the vertex list
    logic [31:0] px_rd, py_rd;
    logic [PW-1:0] paddr;
    assign paddr = cmd.load_point ? PW'(slot_reg) : PW'(vslot_rd);

    pes_ram #(.WIDTH(32), .DEPTH(POINT_ENTRIES)) u_px (
        .clk(clk), .we(cmd.load_point), .waddr(PW'(slot_reg)), .wdata(cx_reg),
        .raddr(paddr), .rdata(px_rd));
    pes_ram #(.WIDTH(32), .DEPTH(POINT_ENTRIES)) u_py (
        .clk(clk), .we(cmd.load_point), .waddr(PW'(slot_reg)), .wdata(cy_reg),
        .raddr(paddr), .rdata(py_rd));

    // vertex texture data is delayed by a register so that it lines up with the point read
    logic [31:0] vu_d_reg, vv_d_reg;
    always_ff @(posedge clk)
    begin
        vu_d_reg <= vu_rd;
        vv_d_reg <= vv_rd;
    end

    // top scan: the read index runs one ahead of the compared one
    logic signed [31:0] best_y_reg;
    logic [CW-1:0]      cmp_idx_reg;
    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.top_init)
            scan_next = '0;
        else if (cmd.top_step)
            scan_next = scan_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= '0;
        else
            scan_reg <= scan_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.top_read)
            cmp_idx_reg <= scan_reg;
        if (cmd.top_cmp)
        begin
            if (cmp_idx_reg == '0 || $signed(py_rd) < best_y_reg)
            begin
                best_y_reg <= py_rd;
                best_reg   <= VW'(cmp_idx_reg);
            end
        end
    end
    assign status.top_last = (cmp_idx_reg + CW'(1)) >= count_eff;

    // edge slot state
    logic signed [15:0] bottoms_reg [2];
    logic signed [31:0] steps_u_reg [2];
    logic signed [31:0] steps_v_reg [2];

    // latched edge operands
    logic signed [31:0] fx_reg, tx_reg, ty_reg, fu_reg, fv_reg, tu2_reg, tv2_reg;
    logic signed [15:0] top_reg, bot_reg;
    logic signed [16:0] rows_reg;
    logic signed [31:0] su_reg, sv_reg, eu_reg, ev_reg;
    logic signed [33:0] dx_reg, du_reg, dv_reg;
    logic signed [32:0] ysum;
    logic signed [15:0] bot_calc;

    assign ysum     = 33'(ty_reg) + 33'(1 <<< (FRACTION_BITS - 1));
    assign bot_calc = 16'(ysum >>> FRACTION_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_from)
        begin
            fx_reg <= px_rd;
            fu_reg <= vu_d_reg;
            fv_reg <= vv_d_reg;
        end
        if (cmd.latch_to)
        begin
            tx_reg  <= px_rd;
            ty_reg  <= py_rd;
            tu2_reg <= vu_d_reg;
            tv2_reg <= vv_d_reg;
            top_reg <= bottoms_reg[sel_reg];
        end
        if (cmd.do_mul)
        begin
            su_reg   <= 32'(fu_reg * $signed({1'b0, texture_width}));
            sv_reg   <= 32'(fv_reg * $signed({1'b0, texture_height}));
            eu_reg   <= 32'(tu2_reg * $signed({1'b0, texture_width}));
            ev_reg   <= 32'(tv2_reg * $signed({1'b0, texture_height}));
            bot_reg  <= bot_calc;
            rows_reg <= 17'(bot_calc) - 17'(top_reg);
        end
        if (cmd.do_diff)
        begin
            dx_reg <= 34'(tx_reg) - 34'(fx_reg);
            du_reg <= 34'(eu_reg) - 34'(su_reg);
            dv_reg <= 34'(ev_reg) - 34'(sv_reg);
        end
    end

    assign status.rows_pos = rows_reg > 0;
    assign status.textured = tex_reg;

    // shared divider
    logic signed [33:0] div_num;
    logic [31:0]        div_q;
    always_comb
    begin
        case (cmd.div_sel)
            DSEL_X:  div_num = dx_reg;
            DSEL_U:  div_num = du_reg;
            DSEL_V:  div_num = dv_reg;
            default: div_num = dx_reg;
        endcase
    end

    pes_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(div_num),
        .divisor(rows_reg), .busy(status.div_busy), .quotient(div_q));

    logic [31:0] qx_reg;

    // slot state update and step capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottoms_reg[0] <= '0;
            bottoms_reg[1] <= '0;
            steps_u_reg[0] <= '0;
            steps_u_reg[1] <= '0;
            steps_v_reg[0] <= '0;
            steps_v_reg[1] <= '0;
        end
        else
        begin
            if (cmd.do_mul)
                bottoms_reg[sel_reg] <= bot_calc;
            if (cmd.div_store && cmd.div_sel == DSEL_U)
                steps_u_reg[sel_reg] <= div_q;
            if (cmd.div_store && cmd.div_sel == DSEL_V)
                steps_v_reg[sel_reg] <= div_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_diff)
            qx_reg <= '0;
        else if (cmd.div_store && cmd.div_sel == DSEL_X)
            qx_reg <= div_q;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_top)
        begin
            top_position <= 4'(best_reg);
            edge_to      <= '0;
            edge_top     <= '0;
            edge_bottom  <= '0;
            start_x      <= '0;
            step_x       <= '0;
            start_u      <= '0;
            start_v      <= '0;
            step_u       <= '0;
            step_v       <= '0;
        end
        else if (cmd.out_edge)
        begin
            top_position <= '0;
            edge_to      <= to_pos;
            edge_top     <= top_reg;
            edge_bottom  <= bot_reg;
            start_x      <= fx_reg;
            step_x       <= qx_reg;
            start_u      <= tex_reg ? su_reg : '0;
            start_v      <= tex_reg ? sv_reg : '0;
            step_u       <= steps_u_reg[sel_reg];
            step_v       <= steps_v_reg[sel_reg];
        end
    end
endmodule

### src/pes_ctrl.sv
// controller state machine sequencing loads, top scan and edge setup
module pes_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pes_pkg::pes_cmd_t    cmd,
    input  pes_pkg::pes_status_t status
);
    import pes_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   load_pend_reg;

    assign in_stall = (state_reg != ST_IDLE) || load_pend_reg || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_LOAD_POINT;
            out_valid_reg <= 1'b0;
            load_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            load_pend_reg <= accept && (op == OP_LOAD_POINT || op == OP_LOAD_VERTEX);
            if (accept)
                op_reg <= op_t'(op);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_FIND_TOP)
                    state_next = ST_TOP_RD;
                else if (accept && op == OP_SETUP_EDGE)
                    state_next = ST_E_RD_FROM;
            end
            ST_TOP_RD:      state_next = ST_TOP_WAIT;
            ST_TOP_WAIT:    state_next = ST_TOP_CMP;
            ST_TOP_CMP:     state_next = status.top_last ? ST_OUT : ST_TOP_RD;
            ST_E_RD_FROM:   state_next = ST_E_WAIT_FROM;
            ST_E_WAIT_FROM: state_next = ST_E_RD_TO;
            ST_E_RD_TO:     state_next = ST_E_WAIT_TO;
            ST_E_WAIT_TO:   state_next = ST_E_LATCH_TO;
            ST_E_LATCH_TO:  state_next = ST_E_MUL;
            ST_E_MUL:       state_next = ST_E_DIFF;
            ST_E_DIFF:
                state_next = status.rows_pos ? ST_DIV_X_START : ST_OUT;
            ST_DIV_X_START: state_next = ST_DIV_X_RUN;
            ST_DIV_X_RUN:
                if (!status.div_busy)
                    state_next = status.textured ? ST_DIV_U_START : ST_OUT;
            ST_DIV_U_START: state_next = ST_DIV_U_RUN;
            ST_DIV_U_RUN:   if (!status.div_busy) state_next = ST_DIV_V_START;
            ST_DIV_V_START: state_next = ST_DIV_V_RUN;
            ST_DIV_V_RUN:   if (!status.div_busy) state_next = ST_OUT;
            ST_OUT:         state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.div_sel    = DSEL_X;
        out_valid_next = out_valid_reg && out_stall;
        cmd.capture    = accept;
        cmd.load_point  = load_pend_reg && op_reg == OP_LOAD_POINT;
        cmd.load_vertex = load_pend_reg && op_reg == OP_LOAD_VERTEX;
        case (state_reg)
            ST_IDLE:
                cmd.top_init = 1'b1;
            ST_TOP_RD:
            begin
                cmd.top_read = 1'b1;
                cmd.top_step = 1'b1;
            end
            ST_TOP_CMP:
                cmd.top_cmp = 1'b1;
            ST_E_RD_FROM:
                cmd.rd_from = 1'b1;
            ST_E_WAIT_FROM:
                cmd.rd_from = 1'b1;
            // start point data arrives as the end vertex read begins
            ST_E_RD_TO:
            begin
                cmd.rd_to      = 1'b1;
                cmd.latch_from = 1'b1;
            end
            ST_E_WAIT_TO:
                cmd.rd_to = 1'b1;
            ST_E_LATCH_TO:
                cmd.latch_to = 1'b1;
            ST_E_MUL:
                cmd.do_mul = 1'b1;
            ST_E_DIFF:
                cmd.do_diff = 1'b1;
            ST_DIV_X_START:
                cmd.div_start = 1'b1;
            ST_DIV_X_RUN:
                cmd.div_store = !status.div_busy;
            ST_DIV_U_START:
            begin
                cmd.div_sel   = DSEL_U;
                cmd.div_start = 1'b1;
            end
            ST_DIV_U_RUN:
            begin
                cmd.div_sel   = DSEL_U;
                cmd.div_store = !status.div_busy;
            end
            ST_DIV_V_START:
            begin
                cmd.div_sel   = DSEL_V;
                cmd.div_start = 1'b1;
            end
            ST_DIV_V_RUN:
            begin
                cmd.div_sel   = DSEL_V;
                cmd.div_store = !status.div_busy;
            end
            ST_OUT:
            begin
                cmd.out_top    = op_reg == OP_FIND_TOP;
                cmd.out_edge   = op_reg == OP_SETUP_EDGE;
                out_valid_next = 1'b1;
            end
            default:
                cmd.top_init = 1'b0;
        endcase
    end

    assign out_valid = out_valid_reg;

    // no new request while a result is pending
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("request accepted with result pending");
    // a result is raised only from the output state
    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");
    // divider is idle when a division starts
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");
endmodule

### src/polygon_edge_setup.sv
// top level of the polygon edge setup block
//
// Requests enter on in_valid/in_stall with op and operand fields; results
// leave on out_valid/out_stall. Registers are written on cfg_valid/cfg_ready
// (index 0 vertex count, 1 texture width, 2 texture height); the user must
// write them only while idle, the block does not enforce it. Load requests
// (op 0, 1) give no result. Find-top (op 2) walks the vertex list through
// the vertex and point memories, reading, waiting and comparing each entry.
// Edge setup (op 3) reads both end vertices, multiplies and subtracts, then,
// for an edge with rows, makes one pass (34 divider steps plus start and
// store) of the shared iterative divider for x and, for textured edges, two
// more for u and v; the result is then given from the output state.
// One request is worked on at a time; the result sits in an output register
// until taken, and no new request is taken while a result waits.
// Reset clears the controller, the edge slot bottoms and texture steps, and
// restores the default registers; the point and vertex tables are unknown
// until written. While out_stall is high the result is held unchanged.
module polygon_edge_setup #(
    parameter int MAX_VERTICES  = 16,
    parameter int POINT_ENTRIES = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [5:0]          point_slot,
    input  logic [3:0]          position,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  tex_u,
    input  logic signed [31:0]  tex_v,
    input  logic signed [1:0]   direction,
    input  logic                edge_sel,
    input  logic                textured,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          top_position,
    output logic [3:0]          edge_to,
    output logic signed [15:0]  edge_top,
    output logic signed [15:0]  edge_bottom,
    output logic signed [31:0]  start_x,
    output logic signed [31:0]  step_x,
    output logic signed [31:0]  start_u,
    output logic signed [31:0]  start_v,
    output logic signed [31:0]  step_u,
    output logic signed [31:0]  step_v,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import pes_pkg::*;

    logic [4:0]  vertex_count_reg;
    logic [12:0] texture_width_reg;
    logic [12:0] texture_height_reg;
    pes_cmd_t    cmd;
    pes_status_t status;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg   <= 5'd3;
            texture_width_reg  <= 13'd256;
            texture_height_reg <= 13'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_VERTEX_COUNT:   vertex_count_reg   <= cfg_data[4:0];
                CFG_TEXTURE_WIDTH:  texture_width_reg  <= cfg_data[12:0];
                CFG_TEXTURE_HEIGHT: texture_height_reg <= cfg_data[12:0];
                default:            vertex_count_reg   <= vertex_count_reg;
            endcase
        end
    end

    pes_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .status(status));

    pes_datapath #(
        .MAX_VERTICES(MAX_VERTICES), .POINT_ENTRIES(POINT_ENTRIES),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .vertex_count(vertex_count_reg), .texture_width(texture_width_reg),
        .texture_height(texture_height_reg), .point_slot(point_slot),
        .position(position), .coord_x(coord_x), .coord_y(coord_y),
        .tex_u(tex_u), .tex_v(tex_v), .direction(direction),
        .edge_sel(edge_sel), .textured(textured),
        .top_position(top_position), .edge_to(edge_to), .edge_top(edge_top),
        .edge_bottom(edge_bottom), .start_x(start_x), .step_x(step_x),
        .start_u(start_u), .start_v(start_v), .step_u(step_u), .step_v(step_v));
endmodule
